### hw/rtl/nearest_segment_route_position_unit_defines.svh
// Assertion macros for the nearest segment route position unit.
`ifndef NEAREST_SEGMENT_ROUTE_POSITION_UNIT_DEFINES_SVH
`define NEAREST_SEGMENT_ROUTE_POSITION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// The property holds at every clock edge out of reset.
`define NSRP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define NSRP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NSRP_ASSERT_ALWAYS(label, prop, msg)
`define NSRP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### hw/rtl/nsrp_pkg.sv
// Shared types and constants of the nearest segment route position unit.
package nsrp_pkg;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [23:0] seg_len;
        logic [31:0] route_start;
        logic [15:0] dir_z;
        logic [15:0] dir_y;
        logic [15:0] dir_x;
        logic [31:0] start_z;
        logic [31:0] start_y;
        logic [31:0] start_x;
    } seg_entry_t;

    localparam int ENTRY_W = $bits(seg_entry_t);

endpackage

### hw/rtl/nsrp_ram.sv
// Generic single write port, single read port RAM with registered read data.
module nsrp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/nsrp_scan.sv
// Streaming squared-distance scan that finds the nearest segment start.
module nsrp_scan
    import nsrp_pkg::*;
#(
    parameter int MAX_SEGMENTS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              go,
    input  logic [$clog2(MAX_SEGMENTS+1)-1:0] count,
    input  logic signed [31:0]                px,
    input  logic signed [31:0]                py,
    input  logic signed [31:0]                pz,
    output logic                              rd_en,
    output logic [$clog2(MAX_SEGMENTS)-1:0]   raddr,
    input  seg_entry_t                        rdata,
    output logic                              done,
    output logic [$clog2(MAX_SEGMENTS)-1:0]   best_idx
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    logic          active_reg, active_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic [CW-1:0] count_reg, count_next;
    logic          v1_reg, v2_reg, v3_reg;
    logic [AW-1:0] idx1_reg, idx2_reg, idx3_reg;
    logic [31:0]   ax_reg, ay_reg, az_reg;
    logic [63:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [65:0]   sum_reg;
    logic [65:0]   best_reg;
    logic [AW-1:0] best_idx_reg;
    logic          done_reg, done_next;
    logic signed [32:0] dx, dy, dz;
    logic [32:0]   mx, my, mz;

    assign rd_en    = active_reg && (issue_reg != count_reg);
    assign raddr    = issue_reg[AW-1:0];
    assign done     = done_reg;
    assign best_idx = best_idx_reg;

    always_comb
    begin
        dx = {px[31], px} - {rdata.start_x[31], rdata.start_x};
        dy = {py[31], py} - {rdata.start_y[31], rdata.start_y};
        dz = {pz[31], pz} - {rdata.start_z[31], rdata.start_z};
        mx = dx[32] ? 33'(-dx) : 33'(dx);
        my = dy[32] ? 33'(-dy) : 33'(dy);
        mz = dz[32] ? 33'(-dz) : 33'(dz);
    end

    always_comb
    begin
        active_next = active_reg;
        issue_next  = issue_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        if (go)
        begin
            active_next = 1'b1;
            issue_next  = '0;
            count_next  = count;
        end
        else if (active_reg)
        begin
            if (rd_en)
            begin
                issue_next = issue_reg + 1'b1;
            end
            else if (!v1_reg && !v2_reg && !v3_reg)
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            issue_reg  <= '0;
            count_reg  <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            issue_reg  <= issue_next;
            count_reg  <= count_next;
            v1_reg     <= rd_en;
            v2_reg     <= v1_reg;
            v3_reg     <= v2_reg;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx1_reg <= raddr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        ax_reg   <= mx[31:0];
        ay_reg   <= my[31:0];
        az_reg   <= mz[31:0];
        sqx_reg  <= ax_reg * ax_reg;
        sqy_reg  <= ay_reg * ay_reg;
        sqz_reg  <= az_reg * az_reg;
        sum_reg  <= {2'b00, sqx_reg} + {2'b00, sqy_reg} + {2'b00, sqz_reg};
    end

    // The first entry always seeds the minimum; later ones replace it only when strictly closer.
    logic v4_reg;
    logic [AW-1:0] idx4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idx4_reg <= idx3_reg;
        if (v4_reg && ((idx4_reg == '0) || (sum_reg < best_reg)))
        begin
            best_reg     <= sum_reg;
            best_idx_reg <= idx4_reg;
        end
    end

endmodule

### hw/rtl/nearest_segment_route_position_unit.sv
// Top level of the nearest segment route position unit.
// A load beat (mode 0) writes one segment entry and never raises busy. A
// query beat (mode 1) scans entries 0 to track_count-1 (capped at MAX_SEGMENTS),
// one table read per cycle, through a four-stage squared distance pipeline,
// then reads the nearest entry and possibly its predecessor to project the
// point. A query with track_count N > 0 holds busy through the scan and each
// projection (one or two of them), and its result appears in the same cycle
// that busy falls; the segment table's single read port serves both the scan
// and the projection fetches, and no new query is taken while busy is high. A
// query with track_count 0 answers in the next cycle with found low. Each result
// is on the result ports for exactly one cycle, marked by result_valid; the
// receiver cannot stall it, so it must take the beat in that cycle.
// track_count may be written only while busy is low and no result is pending.
`include "nearest_segment_route_position_unit_defines.svh"
module nearest_segment_route_position_unit
    import nsrp_pkg::*;
#(
    parameter int MAX_SEGMENTS = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [11:0]        entry_index,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic signed [31:0] start_coord,
    input  logic [23:0]        seg_length,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_data,
    output logic               result_valid,
    output logic               found,
    output logic [11:0]        track_index,
    output logic signed [31:0] route_position
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_FETCH = 8'b0000_0100,
        S_DIFF  = 8'b0000_1000,
        S_MUL   = 8'b0001_0000,
        S_SUM   = 8'b0010_0000,
        S_DEC   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [12:0]        track_count_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [AW-1:0]      best_reg, cand_reg, sel_reg;
    logic               prev_reg;
    logic signed [32:0] rx_reg, ry_reg, rz_reg;
    logic signed [15:0] dx_reg, dy_reg, dz_reg;
    logic signed [31:0] rs_reg, best_rs_reg, sel_rs_reg;
    logic [23:0]        len_reg;
    logic signed [48:0] prx_reg, pry_reg, prz_reg;
    logic signed [50:0] tau_reg;
    logic signed [36:0] q_reg;
    logic               res_valid_reg, res_valid_next;
    logic               found_reg;
    logic [11:0]        track_index_reg;
    logic signed [31:0] route_reg;

    logic               accept;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    seg_entry_t         ram_wdata, ram_rdata;
    logic [31:0]        ei_wide;
    logic [CW-1:0]      count_clamped;
    logic               scan_go, scan_re, scan_done;
    logic [AW-1:0]      scan_raddr, scan_best;
    logic signed [50:0] tau_round;
    logic signed [50:0] len_q22;
    logic signed [37:0] route_sum;
    logic [31:0]        sel_wide;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Loads go straight into the table; slots beyond the table are dropped.
    assign ei_wide   = 32'(entry_index);
    assign ram_we    = accept && (mode == MODE_LOAD) && (ei_wide < 32'(MAX_SEGMENTS));
    assign ram_waddr = ei_wide[AW-1:0];
    always_comb
    begin
        ram_wdata.seg_len     = seg_length;
        ram_wdata.route_start = start_coord;
        ram_wdata.dir_z       = dir_z;
        ram_wdata.dir_y       = dir_y;
        ram_wdata.dir_x       = dir_x;
        ram_wdata.start_z     = pos_z;
        ram_wdata.start_y     = pos_y;
        ram_wdata.start_x     = pos_x;
    end

    assign count_clamped = (32'(track_count_reg) > 32'(MAX_SEGMENTS)) ?
                           CW'(MAX_SEGMENTS) : CW'(track_count_reg);
    assign scan_go = accept && (mode == MODE_QUERY) && (track_count_reg != '0);

    assign ram_re    = scan_re || (state_reg == S_FETCH);
    assign ram_raddr = (state_reg == S_FETCH) ? cand_reg : scan_raddr;

    nsrp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    nsrp_scan #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (scan_go),
        .count    (count_clamped),
        .px       (px_reg),
        .py       (py_reg),
        .pz       (pz_reg),
        .rd_en    (scan_re),
        .raddr    (scan_raddr),
        .rdata    (ram_rdata),
        .done     (scan_done),
        .best_idx (scan_best)
    );

    // Rounding from Q.22 to Q.8 is half up, which is an arithmetic shift after the bias.
    assign tau_round = tau_reg + 51'sd8192;
    assign len_q22   = $signed({13'b0, len_reg, 14'b0});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (scan_go)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FETCH;
                end
            end
            S_FETCH: state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_SUM;
            S_SUM:   state_next = S_DEC;
            S_DEC:
            begin
                if (!prev_reg && tau_reg[50] && (cand_reg != '0))
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign route_sum = 38'(sel_rs_reg) + 38'(q_reg);

    assign res_valid_next = (accept && (mode == MODE_QUERY) && (track_count_reg == '0))
                         || (state_reg == S_FIN);
    assign sel_wide = 32'(sel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            track_count_reg <= '0;
            res_valid_reg   <= 1'b0;
            prev_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                track_count_reg <= cfg_data;
            end
            if (scan_go)
            begin
                prev_reg <= 1'b0;
            end
            else if ((state_reg == S_DEC) && (state_next == S_FETCH))
            begin
                prev_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
        end
        if ((state_reg == S_SCAN) && scan_done)
        begin
            best_reg <= scan_best;
            cand_reg <= scan_best;
        end
        if (state_reg == S_DIFF)
        begin
            rx_reg <= {px_reg[31], px_reg} - {ram_rdata.start_x[31], ram_rdata.start_x};
            ry_reg <= {py_reg[31], py_reg} - {ram_rdata.start_y[31], ram_rdata.start_y};
            rz_reg <= {pz_reg[31], pz_reg} - {ram_rdata.start_z[31], ram_rdata.start_z};
            dx_reg <= ram_rdata.dir_x;
            dy_reg <= ram_rdata.dir_y;
            dz_reg <= ram_rdata.dir_z;
            rs_reg <= ram_rdata.route_start;
            len_reg <= ram_rdata.seg_len;
            if (!prev_reg)
            begin
                best_rs_reg <= ram_rdata.route_start;
            end
        end
        if (state_reg == S_MUL)
        begin
            prx_reg <= rx_reg * dx_reg;
            pry_reg <= ry_reg * dy_reg;
            prz_reg <= rz_reg * dz_reg;
        end
        if (state_reg == S_SUM)
        begin
            tau_reg <= 51'(prx_reg) + 51'(pry_reg) + 51'(prz_reg);
        end
        if (state_reg == S_DEC)
        begin
            if (!prev_reg && !tau_reg[50])
            begin
                sel_reg    <= cand_reg;
                sel_rs_reg <= rs_reg;
                q_reg      <= 37'(tau_round >>> 14);
            end
            else if (!prev_reg && (cand_reg != '0))
            begin
                cand_reg <= cand_reg - 1'b1;
            end
            else if (prev_reg && (tau_reg <= len_q22))
            begin
                sel_reg    <= cand_reg;
                sel_rs_reg <= rs_reg;
                q_reg      <= 37'(tau_round >>> 14);
            end
            else
            begin
                // Fall back to the nearest entry's start coordinate.
                sel_reg    <= best_reg;
                sel_rs_reg <= best_rs_reg;
                q_reg      <= '0;
            end
        end
        if (state_reg == S_FIN)
        begin
            found_reg       <= 1'b1;
            track_index_reg <= sel_wide[11:0];
            if (route_sum > 38'sd2147483647)
            begin
                route_reg <= 32'sh7FFF_FFFF;
            end
            else if (route_sum < -38'sd2147483648)
            begin
                route_reg <= 32'sh8000_0000;
            end
            else
            begin
                route_reg <= route_sum[31:0];
            end
        end
        else if (accept && (mode == MODE_QUERY) && (track_count_reg == '0))
        begin
            found_reg       <= 1'b0;
            track_index_reg <= '0;
            route_reg       <= '0;
        end
    end

    assign result_valid   = res_valid_reg;
    assign found          = found_reg;
    assign track_index    = track_index_reg;
    assign route_position = route_reg;

    `NSRP_ASSERT_ALWAYS(a_result_not_busy, !(result_valid && busy), "result beat while busy")
    `NSRP_ASSERT_NEXT(a_query_progress, accept && (mode == MODE_QUERY), busy || result_valid, "query lost")
    `NSRP_ASSERT_ALWAYS(a_empty_index, found || !result_valid || (track_index == '0), "empty index")
    `NSRP_ASSERT_ALWAYS(a_empty_route, found || !result_valid || (route_position == '0), "empty route")
    `NSRP_ASSERT_NEXT(a_load_idle, accept && (mode == MODE_LOAD), !busy && !result_valid, "load work")

endmodule
